// ===== rtl/rsmp_pkg.sv =====
// Shared types, constants and codes for the polyphase rational resampler.
`timescale 1ns / 1ps
package rsmp_pkg;

  // Parameter defaults
  localparam int TAPS_DEF       = 16;
  localparam int MAX_PHASES_DEF = 32;
  localparam int CHANNELS_DEF   = 4;

  // Fixed field widths
  localparam int FACTOR_W    = 6;
  localparam int ENABLE_W    = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 6;
  localparam int CH_W        = 2;
  localparam int SAMPLE_W    = 16;
  localparam int COEF_W      = 16;
  localparam int COEF_ADDR_W = 9;
  localparam int OFFSET_W    = 7;
  localparam int PHASE_W     = 5;
  localparam int PHASE_LIMIT = 32;
  localparam int FRAC_BITS   = 15;

  localparam int S_TDATA_W = 64;
  localparam int M_TDATA_W = 40;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INTERP = 2'd0,
    REG_DECIM  = 2'd1,
    REG_ENABLE = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    CMD_COEF   = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_code_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MAC,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  // Controller to datapath strobes
  typedef struct packed {
    logic coef_we;
    logic hist_we;
    logic mac_en;
    logic mac_first;
    logic emit;
    logic emit_last;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic busy;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== rtl/polyphase_rational_resampler_top.sv =====
// Top level of the multi-channel P/Q polyphase resampler.
//
//  channel  dir  width  contents
//  s_axis   in   64+1   coefficient write or sample push request
//  m_axis   out  40+1   one resampled complex output request
//  cfg      in   2+6    register write: index 0 P, 1 Q, 2 channel enable
//
// A coefficient write or a dropped sample leaves the block idle. An accepted sample
// adds a setup step and, per output, a tap walk, MAC drain and emit (one tap read
// and MAC per cycle, single-port tap and history memories, 3-stage MAC pipe). Reset
// sets P and Q to 1 and clears enables, history valid bits and per-channel offsets;
// the tap store is undefined until written. The output register holds while m_axis
// stalls; the walk waits on it, and the next input is taken once it is loaded.
`timescale 1ns / 1ps
module polyphase_rational_resampler_top import rsmp_pkg::*; #(
  parameter int TAPS       = TAPS_DEF,
  parameter int MAX_PHASES = MAX_PHASES_DEF,
  parameter int CHANNELS   = CHANNELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // channel, sample_i, sample_q, coef_addr, coef_value, zero pad
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,
  // command
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // out_channel, out_i, out_q, out_phase, zero pad
  output logic [M_TDATA_W-1:0]  m_axis_tdata,
  output logic                  m_axis_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int TAP_AW  = $clog2(MAX_PHASES * TAPS);
  localparam int HIST_AW = $clog2(CHANNELS * TAPS);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  logic [TAP_AW-1:0]          tap_addr;
  logic [HIST_AW-1:0]         hist_addr;
  logic [CH_W-1:0]            emit_ch, out_channel;
  logic [PHASE_W-1:0]         emit_phase, out_phase;
  logic signed [SAMPLE_W-1:0] out_i, out_q;

  // input unpacking
  logic [CH_W-1:0]            in_channel;
  logic signed [SAMPLE_W-1:0] in_i, in_q;
  logic [COEF_ADDR_W-1:0]     in_coef_addr;
  logic signed [COEF_W-1:0]   in_coef;

  assign in_channel   = s_axis_tdata[1:0];
  assign in_i         = s_axis_tdata[17:2];
  assign in_q         = s_axis_tdata[33:18];
  assign in_coef_addr = s_axis_tdata[42:34];
  assign in_coef      = s_axis_tdata[58:43];

  rsmp_ctrl #(
    .TAPS(TAPS), .MAX_PHASES(MAX_PHASES), .CHANNELS(CHANNELS)
  ) u_ctrl (
    .clk, .rst,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_cmd(s_axis_tuser), .in_channel, .in_coef_addr,
    .cmd, .tap_addr, .hist_addr, .emit_ch, .emit_phase, .stat
  );

  rsmp_dp #(
    .TAPS(TAPS), .MAX_PHASES(MAX_PHASES), .CHANNELS(CHANNELS)
  ) u_dp (
    .clk, .rst,
    .cmd, .tap_addr, .hist_addr,
    .coef_value(in_coef), .sample_i(in_i), .sample_q(in_q),
    .emit_ch, .emit_phase, .stat,
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_channel, .out_i, .out_q, .out_phase, .out_last(m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, out_phase, out_q, out_i, out_channel};

endmodule

// ===== rtl/rsmp_ctrl.sv =====
// Resampler controller: config registers, phase walk, tap sequencing.
`timescale 1ns / 1ps
module rsmp_ctrl import rsmp_pkg::*; #(
  parameter int TAPS       = TAPS_DEF,
  parameter int MAX_PHASES = MAX_PHASES_DEF,
  parameter int CHANNELS   = CHANNELS_DEF,
  localparam int TAP_AW    = $clog2(MAX_PHASES * TAPS),
  localparam int HIST_AW   = $clog2(CHANNELS * TAPS)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_cmd,
  input  logic [CH_W-1:0]       in_channel,
  input  logic [COEF_ADDR_W-1:0] in_coef_addr,
  output dp_cmd_t               cmd,
  output logic [TAP_AW-1:0]     tap_addr,
  output logic [HIST_AW-1:0]    hist_addr,
  output logic [CH_W-1:0]       emit_ch,
  output logic [PHASE_W-1:0]    emit_phase,
  input  dp_stat_t              stat
);

  localparam int POS_W  = $clog2(TAPS);
  localparam int CIDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PMAX   = (MAX_PHASES < PHASE_LIMIT) ? MAX_PHASES : PHASE_LIMIT;

  state_t state, state_next;

  logic [FACTOR_W-1:0] interp, decim;
  logic [ENABLE_W-1:0] enable;
  logic [OFFSET_W-1:0] offs [CHANNELS];
  logic [POS_W-1:0]    wpos [CHANNELS];
  logic [CIDX_W-1:0]   ch_cur;
  logic [POS_W-1:0]    head, pos, t;
  logic [OFFSET_W-1:0] r;

  logic                accept, is_sample, ch_ok;
  logic [CIDX_W-1:0]   ch_idx;
  logic [POS_W-1:0]    wp_new;
  logic [FACTOR_W-1:0] p_eff, q_eff;
  logic [OFFSET_W-1:0] p_ext, q_ext, r_step;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid & in_ready;
  assign is_sample = (in_cmd == CMD_SAMPLE);
  assign ch_idx    = CIDX_W'(in_channel);
  assign ch_ok     = (32'(in_channel) < 32'(CHANNELS)) && enable[in_channel];
  assign wp_new    = (wpos[ch_idx] == POS_W'(TAPS - 1)) ? '0 : wpos[ch_idx] + 1'b1;

  // factors clamped to their usable range
  always_comb begin
    p_eff = interp;
    if (interp == '0) p_eff = FACTOR_W'(1);
    else if (32'(interp) > PMAX) p_eff = FACTOR_W'(PMAX);
    q_eff = decim;
    if (decim == '0) q_eff = FACTOR_W'(1);
    else if (32'(decim) > PHASE_LIMIT) q_eff = FACTOR_W'(PHASE_LIMIT);
  end

  assign p_ext  = OFFSET_W'(p_eff);
  assign q_ext  = OFFSET_W'(q_eff);
  assign r_step = r + q_ext;

  always_comb begin
    if (state == ST_IDLE) begin
      tap_addr  = TAP_AW'(in_coef_addr);
      hist_addr = HIST_AW'(ch_idx) * HIST_AW'(TAPS) + HIST_AW'(wp_new);
    end else begin
      tap_addr  = TAP_AW'(r) * TAP_AW'(TAPS) + TAP_AW'(t);
      hist_addr = HIST_AW'(ch_cur) * HIST_AW'(TAPS) + HIST_AW'(pos);
    end
  end

  assign emit_ch    = CH_W'(ch_cur);
  assign emit_phase = r[PHASE_W-1:0];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (accept && is_sample && ch_ok) state_next = ST_SETUP;
      ST_SETUP: state_next = (r < p_ext) ? ST_MAC : ST_IDLE;
      ST_MAC:   if (t == POS_W'(TAPS - 1)) state_next = ST_DRAIN;
      ST_DRAIN: if (!stat.busy) state_next = ST_EMIT;
      ST_EMIT:  if (stat.out_free) state_next = ST_SETUP;
      default:  state_next = ST_IDLE;
    endcase
  end

  // datapath strobes
  always_comb begin
    cmd           = '0;
    cmd.coef_we   = accept && !is_sample &&
                    (32'(in_coef_addr) < MAX_PHASES * TAPS);
    cmd.hist_we   = accept && is_sample && ch_ok;
    cmd.mac_en    = (state == ST_MAC);
    cmd.mac_first = (t == '0);
    cmd.emit      = (state == ST_EMIT) && stat.out_free;
    cmd.emit_last = (r_step >= p_ext);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      interp <= FACTOR_W'(1);
      decim  <= FACTOR_W'(1);
      enable <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        offs[c] <= '0;
        wpos[c] <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        case (cfg_index)
          REG_INTERP: interp <= cfg_data;
          REG_DECIM:  decim  <= cfg_data;
          REG_ENABLE: enable <= cfg_data[ENABLE_W-1:0];
          default:    ;
        endcase
      end
      if (cmd.hist_we) wpos[ch_idx] <= wp_new;
      if (state == ST_SETUP && r >= p_ext) offs[ch_cur] <= r - p_ext;
    end
  end

  // walk registers
  always_ff @(posedge clk) begin
    if (cmd.hist_we) begin
      ch_cur <= ch_idx;
      head   <= wp_new;
      r      <= offs[ch_idx];
    end
    if (state == ST_SETUP) begin
      t   <= '0;
      pos <= head;
    end
    if (state == ST_MAC) begin
      t   <= t + 1'b1;
      pos <= (pos == '0) ? POS_W'(TAPS - 1) : pos - 1'b1;
    end
    if (cmd.emit) r <= r_step;
  end

endmodule

// ===== rtl/rsmp_dp.sv =====
// Resampler datapath: tap and history memories, complex MAC, output register.
`timescale 1ns / 1ps
module rsmp_dp import rsmp_pkg::*; #(
  parameter int TAPS       = TAPS_DEF,
  parameter int MAX_PHASES = MAX_PHASES_DEF,
  parameter int CHANNELS   = CHANNELS_DEF,
  localparam int TAP_AW    = $clog2(MAX_PHASES * TAPS),
  localparam int HIST_AW   = $clog2(CHANNELS * TAPS)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  dp_cmd_t                    cmd,
  input  logic [TAP_AW-1:0]          tap_addr,
  input  logic [HIST_AW-1:0]         hist_addr,
  input  logic signed [COEF_W-1:0]   coef_value,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic signed [SAMPLE_W-1:0] sample_q,
  input  logic [CH_W-1:0]            emit_ch,
  input  logic [PHASE_W-1:0]         emit_phase,
  output dp_stat_t                   stat,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [CH_W-1:0]            out_channel,
  output logic signed [SAMPLE_W-1:0] out_i,
  output logic signed [SAMPLE_W-1:0] out_q,
  output logic [PHASE_W-1:0]         out_phase,
  output logic                       out_last
);

  localparam int TAP_DEPTH  = MAX_PHASES * TAPS;
  localparam int HIST_DEPTH = CHANNELS * TAPS;
  localparam int PROD_W     = SAMPLE_W + COEF_W;
  localparam int ACC_W      = PROD_W + $clog2(TAPS);
  localparam logic signed [ACC_W:0] RND_HALF = (ACC_W + 1)'(1 << (FRAC_BITS - 1));
  localparam logic signed [ACC_W:0] SAT_HI   = (ACC_W + 1)'((1 << (SAMPLE_W - 1)) - 1);
  localparam logic signed [ACC_W:0] SAT_LO   = -(ACC_W + 1)'(1 << (SAMPLE_W - 1));

  logic signed [COEF_W-1:0]     tap_mem  [TAP_DEPTH];
  logic [2*SAMPLE_W-1:0]        hist_mem [HIST_DEPTH];
  logic [HIST_DEPTH-1:0]        hist_vld;

  logic signed [COEF_W-1:0]     tap_rd;
  logic [2*SAMPLE_W-1:0]        hist_rd;
  logic                         hist_rd_vld;
  logic                         v1, first1, v2, first2;
  logic signed [PROD_W-1:0]     prod_i, prod_q;
  logic signed [ACC_W-1:0]      acc_i, acc_q;
  logic signed [SAMPLE_W-1:0]   s_i, s_q;
  logic signed [ACC_W:0]        rnd_i, rnd_q;

  // tap store
  always_ff @(posedge clk) begin
    if (cmd.coef_we) tap_mem[tap_addr] <= coef_value;
    if (cmd.mac_en) tap_rd <= tap_mem[tap_addr];
  end

  // history line, circular per channel; unwritten slots read as zero
  always_ff @(posedge clk) begin
    if (cmd.hist_we) hist_mem[hist_addr] <= {sample_i, sample_q};
    if (cmd.mac_en) begin
      hist_rd     <= hist_mem[hist_addr];
      hist_rd_vld <= hist_vld[hist_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_vld  <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.hist_we) hist_vld[hist_addr] <= 1'b1;
      v1 <= cmd.mac_en;
      v2 <= v1;
      if (cmd.emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  assign s_i = hist_rd_vld ? signed'(hist_rd[2*SAMPLE_W-1:SAMPLE_W]) : '0;
  assign s_q = hist_rd_vld ? signed'(hist_rd[SAMPLE_W-1:0]) : '0;

  always_ff @(posedge clk) begin
    first1 <= cmd.mac_first;
    first2 <= first1;
    prod_i <= s_i * tap_rd;
    prod_q <= s_q * tap_rd;
    if (v2) begin
      acc_i <= first2 ? ACC_W'(prod_i) : acc_i + ACC_W'(prod_i);
      acc_q <= first2 ? ACC_W'(prod_q) : acc_q + ACC_W'(prod_q);
    end
  end

  assign stat.busy     = v1 | v2;
  assign stat.out_free = !out_valid | out_ready;

  // round half up at the Q15 point, then saturate
  assign rnd_i = ((ACC_W + 1)'(acc_i) + RND_HALF) >>> FRAC_BITS;
  assign rnd_q = ((ACC_W + 1)'(acc_q) + RND_HALF) >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_channel <= emit_ch;
      out_phase   <= emit_phase;
      out_last    <= cmd.emit_last;
      if (rnd_i > SAT_HI)      out_i <= SAT_HI[SAMPLE_W-1:0];
      else if (rnd_i < SAT_LO) out_i <= SAT_LO[SAMPLE_W-1:0];
      else                     out_i <= rnd_i[SAMPLE_W-1:0];
      if (rnd_q > SAT_HI)      out_q <= SAT_HI[SAMPLE_W-1:0];
      else if (rnd_q < SAT_LO) out_q <= SAT_LO[SAMPLE_W-1:0];
      else                     out_q <= rnd_q[SAMPLE_W-1:0];
    end
  end

endmodule

// ===== tb/sv/tb_polyphase_rational_resampler_top.sv =====
// Self-checking testbench for the polyphase rational resampler top level.
`timescale 1ns / 1ps
module tb_polyphase_rational_resampler_top;
  import rsmp_pkg::*;

  localparam int NTAPS       = TAPS_DEF;
  localparam int NPHASES     = MAX_PHASES_DEF;
  localparam int NCH         = CHANNELS_DEF;
  localparam int STORE_SIZE  = NTAPS * NPHASES;
  localparam int LOAD_PHASES = 8;
  localparam int LOAD_SIZE   = NTAPS * LOAD_PHASES;
  localparam int WDOG_LIMIT  = 5000;
  localparam int SETTLE      = 50;

  // One request on the input stream
  typedef struct {
    cmd_code_t          cmd;
    logic [1:0]         ch;
    logic signed [15:0] si;
    logic signed [15:0] sq;
    logic [8:0]         addr;
    logic signed [15:0] coef;
  } req_t;

  // One resampled output
  typedef struct packed {
    logic [1:0]         ch;
    logic signed [15:0] oi;
    logic signed [15:0] oq;
    logic [4:0]         phase;
    logic               last;
  } outp_t;

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  polyphase_rational_resampler_top DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Resampler mirror state
  logic [5:0]         interp_p;
  logic [5:0]         decim_q;
  logic [3:0]         ch_enable;
  logic signed [15:0] tap_mem [STORE_SIZE];
  logic signed [15:0] hist_i [NCH][NTAPS];
  logic signed [15:0] hist_q [NCH][NTAPS];
  logic [6:0]         ch_offset [NCH];

  req_t  req_q[$];      // requests waiting for the driver
  outp_t sample_q_exp[$]; // outputs predicted, not yet seen
  req_t  cur_req;
  int    send_idle_pct;
  int    recv_idle_pct;
  bit    hold_start;
  int    hold_cnt;
  int    errors;
  int    quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Rounds half up at bit 15 and saturates to 16 bits.
  function automatic logic signed [15:0] round_sat16(longint acc);
    longint v;
    v = (acc + 16384) >>> 15;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // Applies one accepted request to the mirror and queues its outputs.
  function automatic void resample_request(req_t r);
    int    p, q, ph;
    longint acc_i, acc_q;
    outp_t o;
    bit    any;
    if (r.cmd == CMD_COEF) begin
      tap_mem[r.addr] = r.coef;
      return;
    end
    if (!ch_enable[r.ch]) return;
    for (int t = NTAPS - 1; t > 0; t--) begin
      hist_i[r.ch][t] = hist_i[r.ch][t-1];
      hist_q[r.ch][t] = hist_q[r.ch][t-1];
    end
    hist_i[r.ch][0] = r.si;
    hist_q[r.ch][0] = r.sq;
    p = (interp_p < 1) ? 1 : (interp_p > 32 ? 32 : int'(interp_p));
    q = (decim_q < 1) ? 1 : (decim_q > 32 ? 32 : int'(decim_q));
    ph = int'(ch_offset[r.ch]);
    any = 0;
    while (ph < p) begin
      acc_i = 0;
      acc_q = 0;
      for (int t = 0; t < NTAPS; t++) begin
        acc_i += longint'(hist_i[r.ch][t]) * longint'(tap_mem[ph*NTAPS + t]);
        acc_q += longint'(hist_q[r.ch][t]) * longint'(tap_mem[ph*NTAPS + t]);
      end
      o.ch = r.ch;
      o.oi = round_sat16(acc_i);
      o.oq = round_sat16(acc_q);
      o.phase = ph[4:0];
      o.last = 1'b0;
      sample_q_exp.push_back(o);
      any = 1;
      ph += q;
    end
    // mark the final output of this sample
    if (any) sample_q_exp[sample_q_exp.size()-1].last = 1'b1;
    ch_offset[r.ch] = 7'(ph - p);
  endfunction

  // tdata: channel, sample_i, sample_q, coef_addr, coef_value, zero pad
  function automatic logic [S_TDATA_W-1:0] pack_req(req_t r);
    return {5'b0, r.coef, r.addr, r.sq, r.si, r.ch};
  endfunction

  function automatic logic signed [15:0] rand_value();
    case ($urandom_range(7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'($urandom_range(15) - 8);
      default: return 16'($urandom());
    endcase
  endfunction

  // Random coefficient writes stay inside the loaded part of the tap store.
  function automatic req_t rand_req();
    req_t r;
    r.cmd  = ($urandom_range(99) < 85) ? CMD_SAMPLE : CMD_COEF;
    r.ch   = 2'($urandom_range(3));
    r.si   = rand_value();
    r.sq   = rand_value();
    r.addr = 9'($urandom_range(LOAD_SIZE - 1));
    r.coef = ($urandom_range(1)) ? rand_value() : 16'($urandom_range(8191) - 4096);
    return r;
  endfunction

  function automatic req_t mk_sample(logic [1:0] ch, logic signed [15:0] si,
                                     logic signed [15:0] sq);
    req_t r;
    r = rand_req();
    r.cmd = CMD_SAMPLE;
    r.ch = ch;
    r.si = si;
    r.sq = sq;
    return r;
  endfunction

  function automatic req_t mk_coef(logic [8:0] addr, logic signed [15:0] c);
    req_t r;
    r = rand_req();
    r.cmd = CMD_COEF;
    r.addr = addr;
    r.coef = c;
    return r;
  endfunction

  // Input driver: one request per handshake, random gaps per idle rate.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) resample_request(cur_req);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (req_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_req = req_q.pop_front();
          s_axis_tdata  <= pack_req(cur_req);
          s_axis_tuser  <= cur_req.cmd;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: compares each output with the oldest prediction.
  always @(posedge clk) begin
    outp_t e;
    outp_t a;
    if (rst) begin
      m_axis_tready <= 1'b0;
      hold_cnt = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        a.ch    = m_axis_tdata[1:0];
        a.oi    = m_axis_tdata[17:2];
        a.oq    = m_axis_tdata[33:18];
        a.phase = m_axis_tdata[38:34];
        a.last  = m_axis_tlast;
        if (sample_q_exp.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected output ch=%0d i=%0d q=%0d ph=%0d",
                                     a.ch, a.oi, a.oq, a.phase);
        end else begin
          e = sample_q_exp.pop_front();
          if (a != e) begin
            errors++;
            if (errors <= 10)
              $display("mismatch exp ch=%0d i=%0d q=%0d ph=%0d last=%0b got ch=%0d i=%0d q=%0d ph=%0d last=%0b",
                       e.ch, e.oi, e.oq, e.phase, e.last, a.ch, a.oi, a.oq, a.phase, a.last);
          end
        end
      end
      // long back-pressure stretch so the block fills up
      if (hold_start) begin
        hold_start = 0;
        hold_cnt = 400;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: counts cycles with no handshake anywhere.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [5:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_INTERP: interp_p = val;
      REG_DECIM:  decim_q = val;
      REG_ENABLE: ch_enable = val[3:0];
      default: ;
    endcase
  endtask

  // Waits until every request is taken and every output has come.
  task automatic drain();
    wait (req_q.size() == 0);
    @(posedge clk);
    wait (!s_axis_tvalid);
    wait (sample_q_exp.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Phase settings: P, Q, channel enable (P stays within the loaded branches)
  int phase_p  [8] = '{1, 8, 1, 3, 0, 8, 5, 8};
  int phase_q  [8] = '{1, 1, 32, 2, 0, 63, 7, 3};
  int phase_en [8] = '{11, 15, 5, 15, 10, 15, 14, 15};

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    hold_start = 0;
    send_idle_pct = 7;
    recv_idle_pct = 88;
    interp_p = 1;
    decim_q = 1;
    ch_enable = 0;
    foreach (ch_offset[c]) ch_offset[c] = 0;
    foreach (hist_i[c, t]) begin
      hist_i[c][t] = 0;
      hist_q[c][t] = 0;
    end
    foreach (tap_mem[k]) tap_mem[k] = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Load every branch that can be used so no unwritten entry is ever read.
    for (int k = 0; k < LOAD_SIZE; k++)
      req_q.push_back(mk_coef(9'(k), 16'($urandom_range(8191) - 4096)));
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      send_idle_pct = (ph < 3) ? 7 : (ph < 6) ? 88 : 0;
      recv_idle_pct = (ph < 3) ? 88 : (ph < 6) ? 7 : 0;
      write_reg(REG_INTERP, 6'(phase_p[ph]));
      write_reg(REG_DECIM, 6'(phase_q[ph]));
      write_reg(REG_ENABLE, 6'(phase_en[ph]));
      if (ph == 0) begin
        // extremes, tap edges, and a sample on a disabled channel (ch2)
        req_q.push_back(mk_sample(2'd0, 16'sh7FFF, 16'sh8000));
        req_q.push_back(mk_sample(2'd1, 16'sh8000, 16'sh7FFF));
        req_q.push_back(mk_coef(9'd0, 16'sh7FFF));
        req_q.push_back(mk_coef(9'(STORE_SIZE - 1), 16'sh8000));
        for (int k = 1; k < NTAPS; k++) req_q.push_back(mk_coef(9'(k), 16'sh7FFF));
        for (int k = 0; k < 3; k++)
          req_q.push_back(mk_sample(2'd0, 16'sh7FFF, 16'sh8000));
        req_q.push_back(mk_sample(2'd2, 16'sh1234, 16'sh4321));
        req_q.push_back(mk_sample(2'd3, 16'sh0000, 16'shFFFF));
      end
      if (ph == 1) hold_start = 1;
      for (int k = 0; k < 16; k++) req_q.push_back(rand_req());
      drain();
    end

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
